// ===== rtl/core/vmrl_pkg.sv =====
package vmrl_pkg;

   // field widths
   localparam int VEL_W      = 24;
   localparam int POS_W      = 24;
   localparam int RATIO_W    = 16;
   localparam int RPM_W      = 15;
   localparam int FRAC_W     = 8;
   localparam int REQ_W      = 32;
   localparam int LIM_W      = 24;
   localparam int CMD_W      = 16;

   // csr port
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 24;

   localparam logic [CSR_IDX_W-1:0] CSR_RAISE_RATIO      = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LOWER_RATIO      = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_HARD_POS     = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_HARD_POS     = 8'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_SOFT_POS     = 8'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_SOFT_POS     = 8'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_RPM_LIMIT        = 8'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_ACTIVE_SPEED = 8'd7;

   // internal datapath widths
   localparam int MAG_W  = 28;                   // |requested speed| < 2^28
   localparam int SREQ_W = MAG_W + 1;            // signed requested speed
   localparam int ZONE_W = 24;                   // zone width and distance
   localparam int DEN_W  = ZONE_W + 1;           // 2 * width
   localparam int NUM_W  = MAG_W + ZONE_W + 1;   // 2 * mag * dist + width
   localparam int SPD_W  = RPM_W + FRAC_W;       // clamped speed magnitude

   typedef struct packed {
      logic signed [RATIO_W-1:0] raise_ratio;
      logic signed [RATIO_W-1:0] lower_ratio;
      logic signed [POS_W-1:0]   min_hard_pos;
      logic signed [POS_W-1:0]   max_hard_pos;
      logic signed [POS_W-1:0]   min_soft_pos;
      logic signed [POS_W-1:0]   max_soft_pos;
      logic [RPM_W-1:0]          rpm_limit;
      logic [RPM_W-1:0]          min_active_speed;
   } config_type;

   localparam config_type CFG_RESET = '{
      raise_ratio:      16'sd256,
      lower_ratio:      16'sd256,
      min_hard_pos:     -24'sd23040,
      max_hard_pos:     24'sd23040,
      min_soft_pos:     -24'sd23040,
      max_soft_pos:     24'sd23040,
      rpm_limit:        15'd3000,
      min_active_speed: 15'd1
   };

   // per-beat status that rides along the datapath
   typedef struct packed {
      logic signed [SREQ_W-1:0] requested;
      logic                     neg;
      logic                     nofb;
      logic                     hard;
      logic                     ramp;
   } side_type;

endpackage

// ===== rtl/core/vmrl_if.sv =====
interface vmrl_req_if import vmrl_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [VEL_W-1:0] beam_velocity;
   logic signed [POS_W-1:0] motor_pos;
   logic                    pos_valid;

   modport source (output valid, beam_velocity, motor_pos, pos_valid, input ready);
   modport sink (input valid, beam_velocity, motor_pos, pos_valid, output ready);
endinterface

interface vmrl_rsp_if import vmrl_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [REQ_W-1:0] requested_speed;
   logic signed [LIM_W-1:0] limited_speed;
   logic signed [CMD_W-1:0] command_speed;
   logic                    no_feedback_flag;
   logic                    hard_limit_flag;
   logic                    soft_limit_flag;
   logic                    quantized_flag;

   modport source (output valid, requested_speed, limited_speed, command_speed,
      no_feedback_flag, hard_limit_flag, soft_limit_flag, quantized_flag, input ready);
   modport sink (input valid, requested_speed, limited_speed, command_speed,
      no_feedback_flag, hard_limit_flag, soft_limit_flag, quantized_flag, output ready);
endinterface

interface vmrl_csr_if import vmrl_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/vmrl_csr.sv =====
module vmrl_csr import vmrl_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   vmrl_csr_if.sink   csr_ch,
   output config_type cfg
);

   config_type cfg_ff;
   config_type cfg_in;

   assign csr_ch.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         unique case (csr_ch.index)
            CSR_RAISE_RATIO:      cfg_in.raise_ratio      = csr_ch.data[RATIO_W-1:0];
            CSR_LOWER_RATIO:      cfg_in.lower_ratio      = csr_ch.data[RATIO_W-1:0];
            CSR_MIN_HARD_POS:     cfg_in.min_hard_pos     = csr_ch.data[POS_W-1:0];
            CSR_MAX_HARD_POS:     cfg_in.max_hard_pos     = csr_ch.data[POS_W-1:0];
            CSR_MIN_SOFT_POS:     cfg_in.min_soft_pos     = csr_ch.data[POS_W-1:0];
            CSR_MAX_SOFT_POS:     cfg_in.max_soft_pos     = csr_ch.data[POS_W-1:0];
            CSR_RPM_LIMIT:        cfg_in.rpm_limit        = csr_ch.data[RPM_W-1:0];
            CSR_MIN_ACTIVE_SPEED: cfg_in.min_active_speed = csr_ch.data[RPM_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/core/vmrl_front.sv =====
module vmrl_front import vmrl_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  config_type       cfg,
   vmrl_req_if.sink         req_ch,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [NUM_W-1:0] out_num,
   output logic [DEN_W-1:0] out_den,
   output side_type         out_side
);

   localparam int STAGES  = 6;
   localparam int PROD_W  = VEL_W + RATIO_W;
   localparam int DIFF_W  = POS_W + 1;
   localparam int TRUNC_W = 30;
   localparam int RECIP_W = 32;
   localparam int REC_W   = TRUNC_W + RECIP_W;
   localparam int SCALE_W = MAG_W + ZONE_W;
   // x / 1536 = (x >> 9) / 3, the divide by 3 by reciprocal
   localparam logic [PROD_W-1:0]  HALF_1536   = 40'd768;
   localparam int                 POW2_SHIFT  = 9;
   localparam logic [RECIP_W-1:0] RECIP3      = 32'hAAAA_AAAB;
   localparam int                 RECIP_SHIFT = 33;

   typedef struct packed {
      logic              lo_hard;
      logic              hi_hard;
      logic              lo_zone;
      logic              hi_zone;
      logic [ZONE_W-1:0] lo_w;
      logic [ZONE_W-1:0] lo_d;
      logic [ZONE_W-1:0] hi_w;
      logic [ZONE_W-1:0] hi_d;
   } limits_type;

   logic [STAGES-1:0] v_ff, v_in, v_src, adv;

   // stage 1: ratio multiply
   logic signed [RATIO_W-1:0] ratio_sel;
   logic signed [PROD_W-1:0]  prod1_ff, prod1_in;
   logic signed [POS_W-1:0]   pos1_ff;
   logic                      pv1_ff;

   // stage 2: magnitude, pow2 part of divide, position compares
   logic [PROD_W-1:0]        abs1;
   logic [TRUNC_W-1:0]       t2_ff, t2_in;
   logic                     neg2_ff, pv2_ff;
   logic signed [DIFF_W-1:0] lo_w_full, lo_d_full, hi_w_full, hi_d_full;
   limits_type               lim2_ff, lim2_in;

   // stage 3: divide by 3
   logic [REC_W-1:0]  rec3;
   logic [MAG_W-1:0]  q3_ff, q3_in;
   logic              neg3_ff, pv3_ff;
   limits_type        lim3_ff;

   // stage 4: direction, hard stop, zone select
   logic              mag_nz, spd_neg, spd_pos, hard4, lower4, upper4;
   logic [MAG_W-1:0]  mag4_ff, mag4_in;
   logic [ZONE_W-1:0] w4_ff, w4_in, d4_ff, d4_in;
   side_type          side4_ff, side4_in;

   // stage 5: speed times distance
   logic [SCALE_W-1:0] prod5_ff, prod5_in;
   logic [ZONE_W-1:0]  w5_ff;
   side_type           side5_ff;

   // stage 6: rounding numerator and denominator
   logic [NUM_W-1:0] num6_ff, num6_in;
   logic [DEN_W-1:0] den6_ff, den6_in;
   side_type         side6_ff;

   // ready ripples back, a stage moves when it is empty or its successor moves
   always_comb begin
      logic rdy;
      rdy = out_ready;
      for (int k = STAGES - 1; k >= 0; k--) begin
         adv[k] = !v_ff[k] || rdy;
         rdy    = adv[k];
      end
   end

   assign v_src = {v_ff[STAGES-2:0], req_ch.valid};
   assign v_in  = (adv & v_src) | (~adv & v_ff);
   assign req_ch.ready = adv[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   // stage 1
   always_comb begin
      ratio_sel = req_ch.beam_velocity[VEL_W-1] ? cfg.lower_ratio : cfg.raise_ratio;
      prod1_in  = PROD_W'(req_ch.beam_velocity) * PROD_W'(ratio_sel);
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         prod1_ff <= prod1_in;
         pos1_ff  <= req_ch.motor_pos;
         pv1_ff   <= req_ch.pos_valid;
      end
   end

   // stage 2
   always_comb begin
      abs1  = prod1_ff[PROD_W-1] ? PROD_W'(-prod1_ff) : PROD_W'(prod1_ff);
      t2_in = TRUNC_W'((abs1 + HALF_1536) >> POW2_SHIFT);

      lo_w_full = DIFF_W'(cfg.min_soft_pos) - DIFF_W'(cfg.min_hard_pos);
      lo_d_full = DIFF_W'(pos1_ff) - DIFF_W'(cfg.min_hard_pos);
      hi_w_full = DIFF_W'(cfg.max_hard_pos) - DIFF_W'(cfg.max_soft_pos);
      hi_d_full = DIFF_W'(cfg.max_hard_pos) - DIFF_W'(pos1_ff);

      lim2_in.lo_hard = pos1_ff <= cfg.min_hard_pos;
      lim2_in.hi_hard = pos1_ff >= cfg.max_hard_pos;
      lim2_in.lo_zone = (cfg.min_soft_pos > cfg.min_hard_pos) && (pos1_ff < cfg.min_soft_pos);
      lim2_in.hi_zone = (cfg.max_soft_pos < cfg.max_hard_pos) && (pos1_ff > cfg.max_soft_pos);
      lim2_in.lo_w    = lo_w_full[ZONE_W-1:0];
      lim2_in.hi_w    = hi_w_full[ZONE_W-1:0];
      // past the hard stop the distance clamps to zero
      lim2_in.lo_d    = lo_d_full[DIFF_W-1] ? '0 : lo_d_full[ZONE_W-1:0];
      lim2_in.hi_d    = hi_d_full[DIFF_W-1] ? '0 : hi_d_full[ZONE_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         t2_ff   <= t2_in;
         neg2_ff <= prod1_ff[PROD_W-1];
         pv2_ff  <= pv1_ff;
         lim2_ff <= lim2_in;
      end
   end

   // stage 3
   always_comb begin
      rec3  = REC_W'(t2_ff) * REC_W'(RECIP3);
      q3_in = MAG_W'(rec3 >> RECIP_SHIFT);
   end

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         q3_ff   <= q3_in;
         neg3_ff <= neg2_ff;
         pv3_ff  <= pv2_ff;
         lim3_ff <= lim2_ff;
      end
   end

   // stage 4: a speed rounding to zero counts as no motion
   always_comb begin
      mag_nz  = q3_ff != '0;
      spd_neg = neg3_ff && mag_nz;
      spd_pos = !neg3_ff && mag_nz;
      hard4   = pv3_ff && ((lim3_ff.lo_hard && spd_neg) || (lim3_ff.hi_hard && spd_pos));
      lower4  = pv3_ff && !hard4 && lim3_ff.lo_zone && spd_neg;
      upper4  = pv3_ff && !hard4 && !lower4 && lim3_ff.hi_zone && spd_pos;

      mag4_in = (pv3_ff && !hard4) ? q3_ff : '0;
      // outside a zone the divider sees speed * 1 / 1
      if (lower4) begin
         w4_in = lim3_ff.lo_w;
         d4_in = lim3_ff.lo_d;
      end else if (upper4) begin
         w4_in = lim3_ff.hi_w;
         d4_in = lim3_ff.hi_d;
      end else begin
         w4_in = ZONE_W'(1);
         d4_in = ZONE_W'(1);
      end

      side4_in.requested = !pv3_ff ? '0 :
                           neg3_ff ? -$signed({1'b0, q3_ff}) : $signed({1'b0, q3_ff});
      side4_in.neg  = neg3_ff;
      side4_in.nofb = !pv3_ff;
      side4_in.hard = hard4;
      side4_in.ramp = lower4 || upper4;
   end

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         mag4_ff  <= mag4_in;
         w4_ff    <= w4_in;
         d4_ff    <= d4_in;
         side4_ff <= side4_in;
      end
   end

   // stage 5
   assign prod5_in = SCALE_W'(mag4_ff) * SCALE_W'(d4_ff);

   always_ff @(posedge clock) begin
      if (adv[4]) begin
         prod5_ff <= prod5_in;
         w5_ff    <= w4_ff;
         side5_ff <= side4_ff;
      end
   end

   // stage 6: round half up on magnitude is (2 * n + w) / (2 * w)
   assign num6_in = NUM_W'({prod5_ff, 1'b0}) + NUM_W'(w5_ff);
   assign den6_in = {w5_ff, 1'b0};

   always_ff @(posedge clock) begin
      if (adv[5]) begin
         num6_ff  <= num6_in;
         den6_ff  <= den6_in;
         side6_ff <= side5_ff;
      end
   end

   assign out_valid = v_ff[STAGES-1];
   assign out_num   = num6_ff;
   assign out_den   = den6_ff;
   assign out_side  = side6_ff;

endmodule

// ===== rtl/core/vmrl_div.sv =====
module vmrl_div import vmrl_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [NUM_W-1:0] in_num,
   input  logic [DEN_W-1:0] in_den,
   input  side_type         in_side,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [MAG_W-1:0] out_quot,
   output side_type         out_side
);

   // one quotient bit per stage, restoring form
   localparam int STEPS = MAG_W;

   logic [STEPS-1:0] v_ff, v_in, v_src, adv;
   logic [DEN_W-1:0] rem_ff  [STEPS];
   logic [DEN_W-1:0] rem_in  [STEPS];
   logic [MAG_W-1:0] low_ff  [STEPS];
   logic [MAG_W-1:0] low_in  [STEPS];
   logic [DEN_W-1:0] den_ff  [STEPS];
   side_type         side_ff [STEPS];

   always_comb begin
      logic rdy;
      rdy = out_ready;
      for (int k = STEPS - 1; k >= 0; k--) begin
         adv[k] = !v_ff[k] || rdy;
         rdy    = adv[k];
      end
   end

   assign v_src    = {v_ff[STEPS-2:0], in_valid};
   assign v_in     = (adv & v_src) | (~adv & v_ff);
   assign in_ready = adv[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   for (genvar k = 0; k < STEPS; k++) begin : g_step
      logic [DEN_W-1:0] r_src;
      logic [DEN_W-1:0] d_src;
      logic [MAG_W-1:0] l_src;
      side_type         s_src;
      logic [DEN_W:0]   trial;
      logic             take;

      if (k == 0) begin : g_first
         // quotient fits MAG_W bits, so the top bits start below the divisor
         assign r_src = in_num[NUM_W-1 -: DEN_W];
         assign l_src = in_num[MAG_W-1:0];
         assign d_src = in_den;
         assign s_src = in_side;
      end else begin : g_next
         assign r_src = rem_ff[k-1];
         assign l_src = low_ff[k-1];
         assign d_src = den_ff[k-1];
         assign s_src = side_ff[k-1];
      end

      // low word shifts numerator bits out and quotient bits in
      assign trial     = {r_src, l_src[MAG_W-1]};
      assign take      = trial >= {1'b0, d_src};
      assign rem_in[k] = take ? DEN_W'(trial - {1'b0, d_src}) : trial[DEN_W-1:0];
      assign low_in[k] = {l_src[MAG_W-2:0], take};

      always_ff @(posedge clock) begin
         if (adv[k]) begin
            rem_ff[k]  <= rem_in[k];
            low_ff[k]  <= low_in[k];
            den_ff[k]  <= d_src;
            side_ff[k] <= s_src;
         end
      end
   end

   assign out_valid = v_ff[STEPS-1];
   assign out_quot  = low_ff[STEPS-1];
   assign out_side  = side_ff[STEPS-1];

endmodule

// ===== rtl/core/vmrl_back.sv =====
module vmrl_back import vmrl_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  config_type       cfg,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [MAG_W-1:0] in_quot,
   input  side_type         in_side,
   vmrl_rsp_if.source       rsp_ch
);

   localparam int STAGES = 2;
   localparam logic [SPD_W-1:0] HALF_LSB = SPD_W'(1 << (FRAC_W - 1));

   logic [STAGES-1:0] v_ff, v_in, v_src, adv;

   // clamp stage
   logic [SPD_W-1:0] lim_mag;
   logic [SPD_W-1:0] mag_a_ff, mag_a_in;
   side_type         side_a_ff;

   // output register
   logic [RPM_W-1:0]        cmd_round, cmd_mag;
   logic [SPD_W-1:0]        mag_b_ff;
   logic signed [REQ_W-1:0] req_ff, req_in;
   logic signed [LIM_W-1:0] lim_ff, lim_in;
   logic signed [CMD_W-1:0] cmd_ff, cmd_in;
   logic                    nofb_ff, hard_ff, soft_ff, quant_ff, quant_in;

   always_comb begin
      logic rdy;
      rdy = rsp_ch.ready;
      for (int k = STAGES - 1; k >= 0; k--) begin
         adv[k] = !v_ff[k] || rdy;
         rdy    = adv[k];
      end
   end

   assign v_src    = {v_ff[STAGES-2:0], in_valid};
   assign v_in     = (adv & v_src) | (~adv & v_ff);
   assign in_ready = adv[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   // clamp to rpm limit
   always_comb begin
      lim_mag  = {cfg.rpm_limit, {FRAC_W{1'b0}}};
      mag_a_in = (in_quot > MAG_W'(lim_mag)) ? lim_mag : SPD_W'(in_quot);
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         mag_a_ff  <= mag_a_in;
         side_a_ff <= in_side;
      end
   end

   // integer command, tiny nonzero speeds get the minimum active speed
   always_comb begin
      cmd_round = RPM_W'((mag_a_ff + HALF_LSB) >> FRAC_W);
      cmd_mag   = (cmd_round == '0 && mag_a_ff != '0) ? cfg.min_active_speed : cmd_round;
      quant_in  = {cmd_mag, {FRAC_W{1'b0}}} != mag_a_ff;
      lim_in    = side_a_ff.neg ? -LIM_W'(mag_a_ff) : LIM_W'(mag_a_ff);
      cmd_in    = side_a_ff.neg ? -CMD_W'(cmd_mag) : CMD_W'(cmd_mag);
      req_in    = REQ_W'(side_a_ff.requested);
   end

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         mag_b_ff <= mag_a_ff;
         req_ff   <= req_in;
         lim_ff   <= lim_in;
         cmd_ff   <= cmd_in;
         nofb_ff  <= side_a_ff.nofb;
         hard_ff  <= side_a_ff.hard;
         soft_ff  <= side_a_ff.ramp;
         quant_ff <= quant_in;
      end
   end

   assign rsp_ch.valid            = v_ff[STAGES-1];
   assign rsp_ch.requested_speed  = req_ff;
   assign rsp_ch.limited_speed    = lim_ff;
   assign rsp_ch.command_speed    = cmd_ff;
   assign rsp_ch.no_feedback_flag = nofb_ff;
   assign rsp_ch.hard_limit_flag  = hard_ff;
   assign rsp_ch.soft_limit_flag  = soft_ff;
   assign rsp_ch.quantized_flag   = quant_ff;

   assert property (@(posedge clock) disable iff (reset)
      v_ff[STAGES-1] && (nofb_ff || hard_ff) |-> lim_ff == '0 && cmd_ff == '0 && !quant_ff)
      else $error("blocked or feedback-less beat carries a speed");

   assert property (@(posedge clock) disable iff (reset)
      v_ff[STAGES-1] |-> $countones({nofb_ff, hard_ff, soft_ff}) <= 1)
      else $error("more than one limit status set");

   assert property (@(posedge clock) disable iff (reset)
      v_ff[STAGES-1] && nofb_ff |-> req_ff == '0)
      else $error("requested speed nonzero without feedback");

   assert property (@(posedge clock) disable iff (reset)
      v_ff[STAGES-1] |-> mag_b_ff <= {cfg.rpm_limit, {FRAC_W{1'b0}}})
      else $error("limited speed above rpm limit");

endmodule

// ===== rtl/core/velocity_to_motor_rpm_limiter.sv =====
// channel  | dir | handshake         | payload
// req_ch   | in  | valid / ready     | beam_velocity, motor_pos, pos_valid
// rsp_ch   | out | valid / ready     | requested/limited/command speed, four flags
// csr_ch   | in  | valid / ready (1) | index, data (register write)
//
// one beat in per clock, one beat out per clock while the output is not stalled
// the 28-stage restoring divider does the slow-down zone scaling
// synchronous active-high reset empties every stage and loads register defaults
// a stalled output holds its beat; ready ripples back and only full stages wait,
// so bubbles squeeze out and nothing is dropped or repeated
// csr writes are taken every cycle and are expected only while the pipe is empty
module velocity_to_motor_rpm_limiter import vmrl_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   vmrl_req_if.sink   req_ch,
   vmrl_rsp_if.source rsp_ch,
   vmrl_csr_if.sink   csr_ch
);

   config_type       cfg;

   // front end to divider
   logic             front_valid;
   logic             front_ready;
   logic [NUM_W-1:0] front_num;
   logic [DEN_W-1:0] front_den;
   side_type         front_side;

   // divider to back end
   logic             div_valid;
   logic             div_ready;
   logic [MAG_W-1:0] div_quot;
   side_type         div_side;

   // register file, written through the csr channel
   vmrl_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .cfg    (cfg)
   );

   // ratio multiply, divide by 1536, hard stop and zone decisions,
   // then speed times remaining distance for the zone ramp
   vmrl_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_ch    (req_ch),
      .out_valid (front_valid),
      .out_ready (front_ready),
      .out_num   (front_num),
      .out_den   (front_den),
      .out_side  (front_side)
   );

   // rounded speed times distance over zone width, one quotient bit per stage
   vmrl_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_num    (front_num),
      .in_den    (front_den),
      .in_side   (front_side),
      .out_valid (div_valid),
      .out_ready (div_ready),
      .out_quot  (div_quot),
      .out_side  (div_side)
   );

   // rpm clamp, integer rounding with minimum active speed, output register
   vmrl_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .in_valid (div_valid),
      .in_ready (div_ready),
      .in_quot  (div_quot),
      .in_side  (div_side),
      .rsp_ch   (rsp_ch)
   );

endmodule

// ===== dv/vmrl_cmd_checker.sv =====
module vmrl_cmd_checker import vmrl_pkg::*; (
   input  logic clock,
   input  logic reset,
   vmrl_req_if  req_ch,
   vmrl_rsp_if  rsp_ch,
   vmrl_csr_if  csr_ch,
   output int   fail_count,
   output int   cmds_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   // deg/s to rpm is a divide by 6, the Q8.8 ratio adds 8 fraction bits
   localparam longint RPM_DIV = longint'(6) << FRAC_W;
   localparam longint ONE_RPM = longint'(1) << FRAC_W;
   localparam longint REQ_MAX = (longint'(1) << (REQ_W - 1)) - 1;
   localparam longint REQ_MIN = -(longint'(1) << (REQ_W - 1));

   typedef struct packed {
      logic signed [REQ_W-1:0] requested_speed;
      logic signed [LIM_W-1:0] limited_speed;
      logic signed [CMD_W-1:0] command_speed;
      logic                    no_feedback_flag;
      logic                    hard_limit_flag;
      logic                    soft_limit_flag;
      logic                    quantized_flag;
   } motor_cmd_type;

   config_type limits;
   motor_cmd_type expected_cmds[$];

   // nearest, ties away from zero; den > 0
   function automatic longint round_div(longint num, longint den);
      if (num >= 0)
         return (2 * num + den) / (2 * den);
      return -((2 * (-num) + den) / (2 * den));
   endfunction

   function automatic motor_cmd_type predict_motor_cmd(config_type c,
         logic signed [VEL_W-1:0] vel, logic signed [POS_W-1:0] pos, logic fb_ok);
      motor_cmd_type r;
      longint v, p, gear, req, spd, cmd, w, d, lim;
      longint hard_lo, hard_hi, soft_lo, soft_hi;
      r = '0;
      v = vel;
      p = pos;
      hard_lo = c.min_hard_pos;
      hard_hi = c.max_hard_pos;
      soft_lo = c.min_soft_pos;
      soft_hi = c.max_soft_pos;
      if (!fb_ok) begin
         r.no_feedback_flag = 1'b1;
         return r;
      end
      gear = (v >= 0) ? longint'(c.raise_ratio) : longint'(c.lower_ratio);
      req = round_div(v * gear, RPM_DIV);
      if (req > REQ_MAX) req = REQ_MAX;
      if (req < REQ_MIN) req = REQ_MIN;
      r.requested_speed = req[REQ_W-1:0];
      spd = req;
      if ((p <= hard_lo && spd < 0) || (p >= hard_hi && spd > 0)) begin
         r.hard_limit_flag = 1'b1;
         return r;
      end
      if (soft_lo > hard_lo && spd < 0 && p < soft_lo) begin
         w = soft_lo - hard_lo;
         d = p - hard_lo;
         if (d < 0) d = 0;
         if (d > w) d = w;
         spd = round_div(spd * d, w);
         r.soft_limit_flag = 1'b1;
      end else if (soft_hi < hard_hi && spd > 0 && p > soft_hi) begin
         w = hard_hi - soft_hi;
         d = hard_hi - p;
         if (d < 0) d = 0;
         if (d > w) d = w;
         spd = round_div(spd * d, w);
         r.soft_limit_flag = 1'b1;
      end
      lim = longint'(c.rpm_limit) << FRAC_W;
      if (spd > lim) spd = lim;
      if (spd < -lim) spd = -lim;
      cmd = round_div(spd, ONE_RPM);
      if (cmd == 0 && spd != 0)
         cmd = (spd > 0) ? longint'(c.min_active_speed) : -longint'(c.min_active_speed);
      r.limited_speed = spd[LIM_W-1:0];
      r.command_speed = cmd[CMD_W-1:0];
      r.quantized_flag = (cmd * ONE_RPM != spd);
      return r;
   endfunction

   function automatic void compare_field(string field, logic signed [REQ_W-1:0] want,
         logic signed [REQ_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      motor_cmd_type want;
      if (reset) begin
         limits <= CFG_RESET;
         expected_cmds.delete();
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_cmds.size() == 0) begin
               $error("result beat with no command pending");
               fail_count++;
            end else begin
               want = expected_cmds.pop_front();
               compare_field("requested_speed", want.requested_speed, rsp_ch.requested_speed);
               compare_field("limited_speed", REQ_W'(want.limited_speed),
                             REQ_W'(rsp_ch.limited_speed));
               compare_field("command_speed", REQ_W'(want.command_speed),
                             REQ_W'(rsp_ch.command_speed));
               compare_field("no_feedback_flag", REQ_W'(want.no_feedback_flag),
                             REQ_W'(rsp_ch.no_feedback_flag));
               compare_field("hard_limit_flag", REQ_W'(want.hard_limit_flag),
                             REQ_W'(rsp_ch.hard_limit_flag));
               compare_field("soft_limit_flag", REQ_W'(want.soft_limit_flag),
                             REQ_W'(rsp_ch.soft_limit_flag));
               compare_field("quantized_flag", REQ_W'(want.quantized_flag),
                             REQ_W'(rsp_ch.quantized_flag));
            end
         end
         if (req_ch.valid && req_ch.ready)
            expected_cmds.push_back(predict_motor_cmd(limits, req_ch.beam_velocity,
                                                      req_ch.motor_pos, req_ch.pos_valid));
         if (csr_ch.valid && csr_ch.ready) begin
            case (csr_ch.index)
               CSR_RAISE_RATIO:      limits.raise_ratio <= csr_ch.data[RATIO_W-1:0];
               CSR_LOWER_RATIO:      limits.lower_ratio <= csr_ch.data[RATIO_W-1:0];
               CSR_MIN_HARD_POS:     limits.min_hard_pos <= csr_ch.data[POS_W-1:0];
               CSR_MAX_HARD_POS:     limits.max_hard_pos <= csr_ch.data[POS_W-1:0];
               CSR_MIN_SOFT_POS:     limits.min_soft_pos <= csr_ch.data[POS_W-1:0];
               CSR_MAX_SOFT_POS:     limits.max_soft_pos <= csr_ch.data[POS_W-1:0];
               CSR_RPM_LIMIT:        limits.rpm_limit <= csr_ch.data[RPM_W-1:0];
               CSR_MIN_ACTIVE_SPEED: limits.min_active_speed <= csr_ch.data[RPM_W-1:0];
               default: ;
            endcase
         end
      end
      cmds_pending <= expected_cmds.size();
   end

endmodule

// ===== dv/tb_top.sv =====
module tb_top import vmrl_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   // accept to result runs through the zone divider
   localparam int LATENCY         = 36;
   localparam int NUM_PHASES      = 13;
   localparam int ITEMS_PER_PHASE = 140;
   // long output stall, well past the pipe depth so the input backs up
   localparam int LONG_HOLD       = 200;
   // several times the longest quiet stretch of a correct run
   localparam int QUIET_LIMIT     = 2000;

   localparam longint POS_MAX = (longint'(1) << (POS_W - 1)) - 1;
   localparam longint POS_MIN = -(longint'(1) << (POS_W - 1));

   // register indexes past the map, writes there must be ignored
   localparam int CSR_SPARE_FIRST = CSR_MIN_ACTIVE_SPEED + 1;
   localparam int CSR_SPARE_LAST  = (1 << CSR_IDX_W) - 1;

   logic clock = 1'b0;
   logic reset = 1'b1;

   vmrl_req_if req_if();
   vmrl_rsp_if rsp_if();
   vmrl_csr_if csr_if();

   int fail_count;
   int cmds_pending;

   // stimulus-side copy of the limits, only used to aim positions at zones
   config_type cfg_now = CFG_RESET;
   bit  send_gaps;
   bit  rsp_gaps;
   bit  rsp_hold_req;
   int  samples_sent;
   int  limits_loaded;
   int  quiet_cycles;

   always #5 clock = ~clock;

   velocity_to_motor_rpm_limiter dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if),
      .csr_ch (csr_if)
   );

   vmrl_cmd_checker cmd_check (
      .clock        (clock),
      .reset        (reset),
      .req_ch       (req_if),
      .rsp_ch       (rsp_if),
      .csr_ch       (csr_if),
      .fail_count   (fail_count),
      .cmds_pending (cmds_pending)
   );

   // ---------------------------------------------------------------- helpers

   function automatic logic signed [POS_W-1:0] clamp_pos(longint x);
      if (x > POS_MAX) return POS_MAX[POS_W-1:0];
      if (x < POS_MIN) return POS_MIN[POS_W-1:0];
      return x[POS_W-1:0];
   endfunction

   // random point between two positions, either order
   function automatic longint span_pick(longint a, longint b);
      longint lo, hi;
      lo = (a < b) ? a : b;
      hi = (a < b) ? b : a;
      return lo + longint'($urandom) % (hi - lo + 1);
   endfunction

   function automatic logic signed [RATIO_W-1:0] pick_ratio();
      int step;
      step = int'($urandom_range(1, 1024));
      case ($urandom_range(0, 5))
         0: return 16'sh8000;
         1: return 16'sh7fff;
         2: return RATIO_W'($urandom_range(0, 1) ? -step : step);
         default: return RATIO_W'($urandom);
      endcase
   endfunction

   // soft stop offset into the travel range: zero or negative disables the zone
   function automatic longint zone_offset();
      case ($urandom_range(0, 3))
         0: return 0;
         1: return -longint'($urandom_range(1, 5000));
         default: return longint'($urandom_range(1, 200000));
      endcase
   endfunction

   function automatic config_type random_limits();
      config_type c;
      longint lo, hi;
      c.raise_ratio = pick_ratio();
      c.lower_ratio = pick_ratio();
      case ($urandom_range(0, 7))
         0: begin
            // anything goes, crossed stops included
            lo = span_pick(POS_MIN, POS_MAX);
            hi = span_pick(POS_MIN, POS_MAX);
         end
         1: begin
            lo = POS_MIN;
            hi = POS_MAX;
         end
         default: begin
            lo = -longint'($urandom_range(256, 400000));
            hi = longint'($urandom_range(256, 400000));
         end
      endcase
      c.min_hard_pos = lo[POS_W-1:0];
      c.max_hard_pos = hi[POS_W-1:0];
      c.min_soft_pos = clamp_pos(lo + zone_offset());
      c.max_soft_pos = clamp_pos(hi - zone_offset());
      case ($urandom_range(0, 5))
         0: c.rpm_limit = '0;
         1: c.rpm_limit = '1;
         2: c.rpm_limit = RPM_W'($urandom_range(1, 50));
         default: c.rpm_limit = RPM_W'($urandom_range(100, 12000));
      endcase
      case ($urandom_range(0, 4))
         0: c.min_active_speed = '0;
         1: c.min_active_speed = '1;
         default: c.min_active_speed = RPM_W'($urandom_range(1, 20));
      endcase
      return c;
   endfunction

   function automatic config_type phase_limits(int ph);
      case (ph)
         // plain gearing, both slow-down zones half way to the stops
         0: return '{raise_ratio: 16'sd256, lower_ratio: 16'sd384,
                     min_hard_pos: -24'sd23040, max_hard_pos: 24'sd23040,
                     min_soft_pos: -24'sd11520, max_soft_pos: 24'sd11520,
                     rpm_limit: 15'd3000, min_active_speed: 15'd5};
         // extreme ratios, stops at the ends, zones spanning the whole range
         1: return '{raise_ratio: 16'sh8000, lower_ratio: 16'sh7fff,
                     min_hard_pos: 24'sh800000, max_hard_pos: 24'sh7fffff,
                     min_soft_pos: 24'sh7fffff, max_soft_pos: 24'sh800000,
                     rpm_limit: 15'h7fff, min_active_speed: 15'h7fff};
         // zero rpm limit, zero minimum speed
         2: return '{raise_ratio: 16'sh7fff, lower_ratio: 16'sh8000,
                     min_hard_pos: -24'sd23040, max_hard_pos: 24'sd23040,
                     min_soft_pos: -24'sd11520, max_soft_pos: 24'sd11520,
                     rpm_limit: 15'd0, min_active_speed: 15'd0};
         // defaults again, zones disabled by sitting on the stops
         3: return CFG_RESET;
         // soft points beyond the stops also disable the zones
         4: return '{raise_ratio: -16'sd700, lower_ratio: 16'sd1200,
                     min_hard_pos: -24'sd50000, max_hard_pos: 24'sd40000,
                     min_soft_pos: -24'sd60000, max_soft_pos: 24'sd45000,
                     rpm_limit: 15'd6000, min_active_speed: 15'd2};
         default: return random_limits();
      endcase
   endfunction

   // ---------------------------------------------------------------- drivers

   // keeps valid high from one beat to the next unless a gap is taken
   task automatic send_sample(logic signed [VEL_W-1:0] vel, logic signed [POS_W-1:0] pos,
         logic fb_ok);
      if (send_gaps && $urandom_range(0, 5) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_if.valid         <= 1'b1;
      req_if.beam_velocity <= vel;
      req_if.motor_pos     <= pos;
      req_if.pos_valid     <= fb_ok;
      do @(posedge clock); while (!req_if.ready);
      samples_sent++;
   endtask

   task automatic send_random_sample();
      longint spot, mag, jitter;
      logic signed [VEL_W-1:0] vel;
      jitter = longint'($urandom_range(0, 16)) - 8;
      // mostly aim at the stops and the zones, where the limiter works hardest
      case ($urandom_range(0, 9))
         0: spot = span_pick(POS_MIN, POS_MAX);
         1: spot = cfg_now.min_hard_pos + jitter;
         2: spot = cfg_now.max_hard_pos + jitter;
         3, 4: spot = span_pick(cfg_now.min_hard_pos, cfg_now.min_soft_pos);
         5, 6: spot = span_pick(cfg_now.max_soft_pos, cfg_now.max_hard_pos);
         7: spot = ($urandom_range(0, 1) ? cfg_now.min_soft_pos : cfg_now.max_soft_pos)
                   + jitter;
         default: spot = span_pick(cfg_now.min_hard_pos, cfg_now.max_hard_pos);
      endcase
      case ($urandom_range(0, 7))
         0: vel = VEL_W'($urandom);
         1: begin
            // tiny speeds, rounding ties and the minimum active speed
            mag = longint'($urandom_range(0, 12));
            vel = VEL_W'($urandom_range(0, 1) ? -mag : mag);
         end
         default: begin
            mag = longint'($urandom_range(0, 1 << $urandom_range(6, 22)));
            vel = VEL_W'($urandom_range(0, 1) ? -mag : mag);
         end
      endcase
      send_sample(vel, clamp_pos(spot), $urandom_range(0, 11) != 0);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= data;
      do @(posedge clock); while (!csr_if.ready);
   endtask

   // only called with the pipe empty; unused upper data bits get random junk
   task automatic load_limits(config_type c);
      write_csr(CSR_RAISE_RATIO, {8'($urandom), c.raise_ratio});
      write_csr(CSR_LOWER_RATIO, {8'($urandom), c.lower_ratio});
      write_csr(CSR_MIN_HARD_POS, c.min_hard_pos);
      write_csr(CSR_MAX_HARD_POS, c.max_hard_pos);
      write_csr(CSR_MIN_SOFT_POS, c.min_soft_pos);
      write_csr(CSR_MAX_SOFT_POS, c.max_soft_pos);
      write_csr(CSR_RPM_LIMIT, {9'($urandom), c.rpm_limit});
      write_csr(CSR_MIN_ACTIVE_SPEED, {9'($urandom), c.min_active_speed});
      // a write past the register map must change nothing
      write_csr(CSR_IDX_W'($urandom_range(CSR_SPARE_FIRST, CSR_SPARE_LAST)),
                CSR_DATA_W'($urandom));
      csr_if.valid <= 1'b0;
      cfg_now = c;
      limits_loaded++;
   endtask

   // first look waits for a clock edge, so a beat accepted just now is counted
   task automatic drain_results();
      do @(posedge clock); while (cmds_pending != 0);
   endtask

   task automatic send_directed();
      send_sample(24'sh7fffff, '0, 1'b0);                // lost feedback, top velocity
      send_sample(24'sh800000, 24'sh800000, 1'b0);       // lost feedback, bottom values
      send_sample('0, '0, 1'b1);                         // standing still
      send_sample(24'sh7fffff, '0, 1'b1);                // clamp at +rpm limit
      send_sample(24'sh800000, '0, 1'b1);                // clamp at -rpm limit
      send_sample(24'sd1, '0, 1'b1);                     // rounds to no motion
      send_sample(24'sd3, '0, 1'b1);                     // tie up to 1, then minimum speed
      send_sample(-24'sd2, '0, 1'b1);                    // tie down to -1, negative minimum
      send_sample(24'sd1536, '0, 1'b1);                  // exactly 1 rpm, not quantized
      send_sample(24'sd768, '0, 1'b1);                   // half rpm rounds up
      send_sample(-24'sd512, '0, 1'b1);                  // minus half rpm rounds away
      send_sample(24'sd6000, 24'sd23040, 1'b1);          // on upper stop, pushing out
      send_sample(-24'sd6000, -24'sd23040, 1'b1);        // on lower stop, pushing out
      send_sample(24'sd6000, 24'sh7fffff, 1'b1);         // far past upper stop
      send_sample(-24'sd6000, 24'sh800000, 1'b1);        // far past lower stop
      send_sample(-24'sd6000, 24'sd23040, 1'b1);         // on upper stop, backing off
      send_sample('0, 24'sd23040, 1'b1);                 // on a stop, no motion
      send_sample(24'sd6000, 24'sd20000, 1'b1);          // inside upper zone
      send_sample(24'sd6000, 24'sd11520, 1'b1);          // on the upper zone edge
      send_sample(24'sd6000, 24'sd11521, 1'b1);          // just inside upper zone
      send_sample(-24'sd6000, -24'sd20000, 1'b1);        // inside lower zone
      send_sample(24'sd6000, -24'sd20000, 1'b1);         // lower zone, moving away
      send_sample(24'sh800000, -24'sd23039, 1'b1);       // deep lower zone, scaled below the rpm clamp
   endtask

   // ---------------------------------------------------------------- stimulus

   initial begin : stimulus
      bit quiet_tail;
      int mode;
      req_if.valid         <= 1'b0;
      req_if.beam_velocity <= '0;
      req_if.motor_pos     <= '0;
      req_if.pos_valid     <= 1'b0;
      csr_if.valid         <= 1'b0;
      csr_if.index         <= '0;
      csr_if.data          <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         load_limits(phase_limits(ph));
         // the last phases run flat out on both sides
         quiet_tail = (ph >= NUM_PHASES - 2);
         mode = int'($urandom_range(0, 3));
         send_gaps = !quiet_tail && mode != 2;
         rsp_gaps = !quiet_tail && mode != 1;
         if (ph == 0)
            send_directed();
         if (ph == 1) begin
            // back-pressure: output stalls while input keeps coming
            send_gaps = 1'b0;
            rsp_hold_req = 1'b1;
         end
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (ph == 2 && n == ITEMS_PER_PHASE / 2) begin
               // sender sits out until the pipe has fully emptied
               req_if.valid <= 1'b0;
               drain_results();
            end
            send_random_sample();
         end
         req_if.valid <= 1'b0;
         drain_results();
      end

      repeat (LATENCY + 8) @(posedge clock);
      $display("%0d speed samples under %0d limit settings: stops, slow-down zones,",
               samples_sent, limits_loaded);
      $display("rpm clamps, rounding ties, minimum speed, lost feedback, ignored writes");
      if (fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   // result side: random stall bursts, plus one long hold on request
   initial begin : result_sink
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_req) begin
            rsp_if.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            rsp_hold_req = 1'b0;
         end else if (rsp_gaps && $urandom_range(0, 7) == 0) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
      end
   end

   // watchdog: too long with no beat on any channel means a hang
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
            || (csr_if.valid && csr_if.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule
